>>> rtl/ecc_pkg.sv
// ---------------------------------------------------------------------------
// ecc_pkg: shared types, codes and helpers
// Floor count, lamp layout, record codes, phase commands and status structs,
// plus the small request-bitmap helpers used by the datapath.
// ---------------------------------------------------------------------------
package ecc_pkg;

    localparam int FLOORS   = 4;
    localparam int FLW      = 2;
    localparam int NBTN     = 3 * FLOORS;
    localparam int LAMPW    = NBTN + 2;
    localparam int DOOR_BIT = NBTN;
    localparam int STOP_BIT = NBTN + 1;
    localparam int BIW      = $clog2(NBTN);

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_WAIT    = 2'd1;
    localparam logic [1:0] MODE_STOPPED = 2'd2;
    localparam logic [1:0] MODE_HALTED  = 2'd3;

    localparam logic [3:0] CT_UP_PRESSED   = 4'd0;
    localparam logic [3:0] CT_DOWN_PRESSED = 4'd1;
    localparam logic [3:0] CT_IN_PRESSED   = 4'd2;
    localparam logic [3:0] CT_SERVED       = 4'd3;
    localparam logic [3:0] CT_SERVED_UP    = 4'd4;
    localparam logic [3:0] CT_SERVED_DOWN  = 4'd5;
    localparam logic [3:0] CT_OTHER        = 4'd6;
    localparam logic [3:0] CT_KEEPALIVE    = 4'd7;
    localparam logic [3:0] CT_STEP_END     = 4'd8;
    localparam logic [3:0] CT_HALTED       = 4'd9;

    localparam logic [2:0] ACT_CALL_UP  = 3'd1;
    localparam logic [2:0] ACT_CALL_DN  = 3'd2;
    localparam logic [2:0] ACT_UP_ON    = 3'd3;
    localparam logic [2:0] ACT_UP_OFF   = 3'd4;
    localparam logic [2:0] ACT_DN_ON    = 3'd5;
    localparam logic [2:0] ACT_DN_OFF   = 3'd6;

    localparam logic [1:0] BTN_TARGET = 2'd0;
    localparam logic [1:0] BTN_UP     = 2'd1;
    localparam logic [1:0] BTN_DOWN   = 2'd2;

    localparam logic       CFG_DOOR_WAIT  = 1'b0;
    localparam logic       CFG_KEEP_ALIVE = 1'b1;

    localparam logic signed [2:0] FLOOR_UNKNOWN = -3'sd1;

    typedef enum logic [3:0] {
        PH_NONE, PH_HALT, PH_BTN, PH_STOP, PH_OBS, PH_CMD, PH_FLOOR,
        PH_MAIN, PH_CLR, PH_WAIT2, PH_KA, PH_END
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [FLW-1:0]   fl;
        logic [1:0]       kind;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic last;
    } stat_t;

    function automatic logic [1:0] best_dir(input logic [FLOORS-1:0] ins,
                                            input logic [FLOORS-1:0] up,
                                            input logic [FLOORS-1:0] dn,
                                            input logic [FLW-1:0] lsf);
        logic [FLOORS-1:0] s;
        logic [FLW:0] hi;
        logic [FLW:0] lo;
        s = (ins == '0) ? (up | dn) : ins;
        hi = '0;
        lo = '0;
        for (int f = 0; f < FLOORS; f++)
        begin
            if (s[f] && f > int'(lsf))
                hi = hi + 1'b1;
            if (s[f] && f < int'(lsf))
                lo = lo + 1'b1;
        end
        return (hi >= lo) ? DIR_UP : DIR_DOWN;
    endfunction

    function automatic logic should_stop(input logic [FLOORS-1:0] ins,
                                         input logic [FLOORS-1:0] up,
                                         input logic [FLOORS-1:0] dn,
                                         input logic [1:0] dir,
                                         input logic [FLW-1:0] f);
        logic [FLOORS-1:0] bit_m;
        logic [FLOORS-1:0] all_m;
        bit_m = FLOORS'(1) << f;
        all_m = ins | up | dn;
        if ((ins & bit_m) != '0)
            return 1'b1;
        if (dir == DIR_UP && (up & bit_m) != '0)
            return 1'b1;
        if (dir == DIR_DOWN && (dn & bit_m) != '0)
            return 1'b1;
        return ((all_m & bit_m) != '0) &&
               ((all_m & ~bit_m) == '0 || all_m == up || all_m == dn);
    endfunction

    function automatic logic prio_in(input logic [FLOORS-1:0] ins,
                                     input logic [1:0] dir,
                                     input logic [FLW-1:0] lsf);
        logic [FLOORS-1:0] below;
        logic [FLOORS-1:0] above;
        below = (FLOORS'(1) << lsf) - FLOORS'(1);
        above = ~(below | (FLOORS'(1) << lsf));
        if (dir == DIR_DOWN)
            return (ins & below) != '0;
        if (dir == DIR_UP)
            return (ins & above) != '0;
        return 1'b0;
    endfunction

    function automatic logic [1:0] start_dir(input logic [1:0] dir,
                                             input logic [FLW-1:0] lsf,
                                             input logic [FLOORS-1:0] ins,
                                             input logic [FLOORS-1:0] up,
                                             input logic [FLOORS-1:0] dn);
        logic [1:0] d;
        d = dir;
        if (lsf == '0)
            d = DIR_UP;
        else if (lsf == FLW'(FLOORS - 1))
            d = DIR_DOWN;
        if (d == DIR_NONE)
            d = best_dir(ins, up, dn, lsf);
        return d;
    endfunction

endpackage

>>> rtl/ecc_in_if.sv
// ---------------------------------------------------------------------------
// ecc_in_if: poll item channel
// Valid/ready channel carrying one poll cycle of car inputs.
// ---------------------------------------------------------------------------
interface ecc_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] button_signals;
    logic        stop_button;
    logic        obstruction;
    logic signed [2:0] floor_sensor;
    logic [2:0]  action;
    logic [1:0]  command_floor;
    logic [31:0] time_now;

    modport source (output valid, button_signals, stop_button, obstruction,
                    floor_sensor, action, command_floor, time_now, input ready);
    modport sink (input valid, button_signals, stop_button, obstruction,
                  floor_sensor, action, command_floor, time_now, output ready);
endinterface

// ---------------------------------------------------------------------------
// ecc_out_if: record channel
// Valid/ready channel carrying one state-change record per item.
// ---------------------------------------------------------------------------
interface ecc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  change_type;
    logic signed [2:0] change_floor;
    logic [1:0]  last_floor;
    logic [1:0]  direction;
    logic [3:0]  inside_requests;
    logic [3:0]  up_requests;
    logic [3:0]  down_requests;
    logic        stopped;
    logic [13:0] lamps;
    logic [1:0]  floor_indicator;
    logic [31:0] timestamp;
    logic        last_of_step;

    modport source (output valid, change_type, change_floor, last_floor, direction,
                    inside_requests, up_requests, down_requests, stopped, lamps,
                    floor_indicator, timestamp, last_of_step, input ready);
    modport sink (input valid, change_type, change_floor, last_floor, direction,
                  inside_requests, up_requests, down_requests, stopped, lamps,
                  floor_indicator, timestamp, last_of_step, output ready);
endinterface

>>> rtl/ecc_ctrl.sv
// ---------------------------------------------------------------------------
// ecc_ctrl: step sequencer
// Walks one poll item through its phases, one phase per free output slot.
// ---------------------------------------------------------------------------
module ecc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ecc_pkg::stat_t   stat,
    output ecc_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_HALT, S_BTN, S_STOP, S_OBS, S_CMD, S_FLOOR,
        S_MAIN, S_CLR, S_WAIT2, S_KA, S_END
    } state_t;

    state_t state_reg, state_next;
    logic [ecc_pkg::FLW-1:0] fl_reg, fl_next;
    logic [1:0] kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        case (state_reg)
            S_HALT:  cmd.phase = ecc_pkg::PH_HALT;
            S_BTN:   cmd.phase = ecc_pkg::PH_BTN;
            S_STOP:  cmd.phase = ecc_pkg::PH_STOP;
            S_OBS:   cmd.phase = ecc_pkg::PH_OBS;
            S_CMD:   cmd.phase = ecc_pkg::PH_CMD;
            S_FLOOR: cmd.phase = ecc_pkg::PH_FLOOR;
            S_MAIN:  cmd.phase = ecc_pkg::PH_MAIN;
            S_CLR:   cmd.phase = ecc_pkg::PH_CLR;
            S_WAIT2: cmd.phase = ecc_pkg::PH_WAIT2;
            S_KA:    cmd.phase = ecc_pkg::PH_KA;
            S_END:   cmd.phase = ecc_pkg::PH_END;
            default: cmd.phase = ecc_pkg::PH_NONE;
        endcase
        cmd.fl   = fl_reg;
        cmd.kind = kind_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        fl_next    = fl_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HALT;
                    fl_next    = '0;
                    kind_next  = ecc_pkg::BTN_TARGET;
                end
            end
            default:
            begin
                if (stat.go)
                begin
                    if (stat.last)
                        state_next = S_IDLE;
                    else
                    begin
                        case (state_reg)
                            S_HALT:  state_next = S_BTN;
                            S_BTN:
                            begin
                                // buttons in order target, up, down per floor
                                if (kind_reg == ecc_pkg::BTN_DOWN)
                                begin
                                    kind_next = ecc_pkg::BTN_TARGET;
                                    fl_next   = fl_reg + 1'b1;
                                    if (fl_reg == ecc_pkg::FLW'(ecc_pkg::FLOORS - 1))
                                        state_next = S_STOP;
                                end
                                else
                                    kind_next = kind_reg + 1'b1;
                            end
                            S_STOP:  state_next = S_OBS;
                            S_OBS:   state_next = S_CMD;
                            S_CMD:   state_next = S_FLOOR;
                            S_FLOOR: state_next = S_MAIN;
                            S_MAIN:  state_next = S_CLR;
                            S_CLR:   state_next = S_WAIT2;
                            S_WAIT2: state_next = S_KA;
                            S_KA:    state_next = S_END;
                            default: state_next = S_IDLE;
                        endcase
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fl_reg    <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fl_reg    <= fl_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

>>> rtl/ecc_datapath.sv
// ---------------------------------------------------------------------------
// ecc_datapath: car state and record register
// Holds the request bitmaps, lamps, direction and mode, applies one phase
// per command and loads the output record register.
// ---------------------------------------------------------------------------
module ecc_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             accept,
    input  logic [11:0]      button_signals,
    input  logic             stop_button,
    input  logic             obstruction,
    input  logic [2:0]       floor_sensor,
    input  logic [2:0]       action,
    input  logic [1:0]       command_floor,
    input  logic [31:0]      time_now,
    input  ecc_pkg::cmd_t    cmd,
    output ecc_pkg::stat_t   stat,
    ecc_out_if.source        out_ch
);

    localparam int FL = ecc_pkg::FLOORS;
    localparam int FW = ecc_pkg::FLW;
    localparam int LW = ecc_pkg::LAMPW;

    // latched item
    logic [ecc_pkg::NBTN-1:0] sig_q;
    logic stop_q, obs_q, sok_q;
    logic [FW-1:0] sf_q;
    logic [2:0] act_q;
    logic [1:0] cfl_q;
    logic [31:0] time_q;

    // car state
    logic [1:0] mode_reg, mode_next, dir_reg, dir_next, pdir_reg, pdir_next;
    logic [FW-1:0] lsf_reg, lsf_next, shown_reg, shown_next;
    logic [FL-1:0] ins_reg, ins_next, up_reg, up_next, dn_reg, dn_next;
    logic [FL-1:0] ipb_reg, ipb_next, pn_reg, pn_next;
    logic [LW-1:0] lamp_reg, lamp_next;
    logic stopb_reg, stopb_next, estop_reg, estop_next;
    logic signed [2:0] fb_reg, fb_next;
    logic [31:0] dst_reg, dst_next, lrt_reg, lrt_next;
    logic [15:0] dwt_reg, kat_reg;
    logic clrp_reg, clrp_next, to_reg, to_next;

    logic out_valid_reg;
    logic go;
    logic em, em_last;
    logic [3:0] em_type;
    logic signed [2:0] em_floor;
    logic signed [2:0] cf;

    assign go = !out_valid_reg || out_ch.ready;
    assign cf = sok_q ? $signed({1'b0, sf_q}) : ecc_pkg::FLOOR_UNKNOWN;
    assign stat.go = go;
    assign stat.last = em && em_last;

    always_comb
    begin
        logic [ecc_pkg::BIW-1:0] b;
        logic exists;
        logic [FL-1:0] fbit;
        logic [FL-1:0] cbit;
        logic [1:0] kind;
        logic up_ok, dn_ok, timeout;
        logic [LW-1:0] upm, dnm;

        mode_next  = mode_reg;
        dir_next   = dir_reg;
        pdir_next  = pdir_reg;
        lsf_next   = lsf_reg;
        shown_next = shown_reg;
        ins_next   = ins_reg;
        up_next    = up_reg;
        dn_next    = dn_reg;
        ipb_next   = ipb_reg;
        pn_next    = pn_reg;
        lamp_next  = lamp_reg;
        stopb_next = stopb_reg;
        estop_next = estop_reg;
        fb_next    = fb_reg;
        dst_next   = dst_reg;
        clrp_next  = clrp_reg;
        to_next    = to_reg;
        em         = 1'b0;
        em_last    = 1'b0;
        em_type    = ecc_pkg::CT_OTHER;
        em_floor   = cf;

        b = ecc_pkg::BIW'(3 * int'(cmd.fl) + int'(cmd.kind));
        fbit = FL'(1) << cmd.fl;
        cbit = FL'(1) << sf_q;
        exists = !((cmd.kind == ecc_pkg::BTN_UP && cmd.fl == FW'(FL - 1)) ||
                   (cmd.kind == ecc_pkg::BTN_DOWN && cmd.fl == '0));
        up_ok = (cfl_q != FW'(FL - 1));
        dn_ok = (cfl_q != '0);
        upm = LW'(1) << (3 * int'(cfl_q) + 1);
        dnm = LW'(1) << (3 * int'(cfl_q) + 2);
        timeout = (time_q - dst_reg) > {16'd0, dwt_reg};
        kind = ecc_pkg::DIR_NONE;

        case (cmd.phase)
            ecc_pkg::PH_HALT:
            begin
                if (mode_reg == ecc_pkg::MODE_HALTED)
                begin
                    em = 1'b1;
                    em_last = 1'b1;
                    em_type = ecc_pkg::CT_HALTED;
                    em_floor = ecc_pkg::FLOOR_UNKNOWN;
                end
            end
            ecc_pkg::PH_BTN:
            begin
                if (exists && sig_q[b])
                begin
                    if (!lamp_reg[b])
                    begin
                        lamp_next[b] = 1'b1;
                        if (cmd.kind == ecc_pkg::BTN_TARGET)
                            ins_next = ins_reg | fbit;
                        em = 1'b1;
                        em_floor = $signed({1'b0, cmd.fl});
                        case (cmd.kind)
                            ecc_pkg::BTN_TARGET: em_type = ecc_pkg::CT_IN_PRESSED;
                            ecc_pkg::BTN_UP:     em_type = ecc_pkg::CT_UP_PRESSED;
                            default:             em_type = ecc_pkg::CT_DOWN_PRESSED;
                        endcase
                    end
                    if (cmd.kind == ecc_pkg::BTN_TARGET)
                        pn_next = pn_reg | fbit;
                end
            end
            ecc_pkg::PH_STOP:
            begin
                if (stop_q && !stopb_reg)
                begin
                    if (sok_q)
                        lsf_next = sf_q;
                    estop_next = !lamp_reg[ecc_pkg::STOP_BIT];
                    if (!lamp_reg[ecc_pkg::STOP_BIT])
                    begin
                        lamp_next[ecc_pkg::STOP_BIT] = 1'b1;
                        if (dir_reg != ecc_pkg::DIR_NONE)
                            pdir_next = dir_reg;
                        dir_next = ecc_pkg::DIR_NONE;
                        mode_next = ecc_pkg::MODE_STOPPED;
                    end
                    else
                    begin
                        lamp_next[ecc_pkg::STOP_BIT] = 1'b0;
                        lamp_next[ecc_pkg::DOOR_BIT] = 1'b0;
                        dir_next = ecc_pkg::start_dir(pdir_reg, lsf_next, ins_reg,
                                                      up_reg, dn_reg);
                        mode_next = ecc_pkg::MODE_NORMAL;
                    end
                    em = 1'b1;
                end
                stopb_next = stop_q;
            end
            ecc_pkg::PH_OBS:
            begin
                if (obs_q)
                begin
                    if (dir_reg != ecc_pkg::DIR_NONE)
                        pdir_next = dir_reg;
                    dir_next = ecc_pkg::DIR_NONE;
                    mode_next = ecc_pkg::MODE_HALTED;
                    em = 1'b1;
                    em_last = 1'b1;
                    em_type = ecc_pkg::CT_HALTED;
                    em_floor = ecc_pkg::FLOOR_UNKNOWN;
                end
            end
            ecc_pkg::PH_CMD:
            begin
                case (act_q)
                    ecc_pkg::ACT_CALL_UP:
                        if (up_ok)
                        begin
                            up_next = up_reg | (FL'(1) << cfl_q);
                            lamp_next = lamp_reg | upm;
                        end
                    ecc_pkg::ACT_CALL_DN:
                        if (dn_ok)
                        begin
                            dn_next = dn_reg | (FL'(1) << cfl_q);
                            lamp_next = lamp_reg | dnm;
                        end
                    ecc_pkg::ACT_UP_ON:  if (up_ok) lamp_next = lamp_reg | upm;
                    ecc_pkg::ACT_UP_OFF: if (up_ok) lamp_next = lamp_reg & ~upm;
                    ecc_pkg::ACT_DN_ON:  if (dn_ok) lamp_next = lamp_reg | dnm;
                    ecc_pkg::ACT_DN_OFF: if (dn_ok) lamp_next = lamp_reg & ~dnm;
                    default: ;
                endcase
            end
            ecc_pkg::PH_FLOOR:
            begin
                if (sok_q)
                begin
                    lsf_next = sf_q;
                    shown_next = sf_q;
                    if ((sf_q == FW'(FL - 1) && dir_reg == ecc_pkg::DIR_UP) ||
                        (sf_q == '0 && dir_reg == ecc_pkg::DIR_DOWN))
                    begin
                        pdir_next = dir_reg;
                        dir_next = ecc_pkg::DIR_NONE;
                    end
                end
                if (cf != fb_reg)
                    em = 1'b1;
            end
            ecc_pkg::PH_MAIN:
            begin
                clrp_next = 1'b0;
                to_next = 1'b0;
                ipb_next = pn_reg;
                if (mode_reg == ecc_pkg::MODE_NORMAL)
                begin
                    if (sok_q && ecc_pkg::should_stop(ins_reg, up_reg, dn_reg, dir_reg, sf_q))
                    begin
                        lamp_next[3 * int'(sf_q)] = 1'b0;
                        ins_next = ins_reg & ~cbit;
                        lamp_next[ecc_pkg::DOOR_BIT] = 1'b1;
                        mode_next = ecc_pkg::MODE_WAIT;
                        dst_next = time_q;
                        if (dir_reg != ecc_pkg::DIR_NONE)
                            pdir_next = dir_reg;
                        dir_next = ecc_pkg::DIR_NONE;
                        em = 1'b1;
                        em_type = ecc_pkg::CT_SERVED;
                    end
                    else if (dir_reg == ecc_pkg::DIR_NONE)
                    begin
                        clrp_next = 1'b1;
                        if ((ins_reg | up_reg | dn_reg) != '0)
                        begin
                            dir_next = ecc_pkg::start_dir(
                                ecc_pkg::prio_in(ins_reg, pdir_reg, lsf_reg) ?
                                    pdir_reg : ecc_pkg::DIR_NONE,
                                lsf_reg, ins_reg, up_reg, dn_reg);
                            lamp_next[ecc_pkg::DOOR_BIT] = 1'b0;
                            em = 1'b1;
                        end
                    end
                end
                else if (mode_reg == ecc_pkg::MODE_WAIT)
                begin
                    if ((pn_reg & ~ipb_reg) != '0 || timeout)
                    begin
                        lamp_next[ecc_pkg::DOOR_BIT] = 1'b0;
                        mode_next = ecc_pkg::MODE_NORMAL;
                        if (timeout)
                        begin
                            if (sok_q)
                            begin
                                up_next = up_reg & ~cbit;
                                dn_next = dn_reg & ~cbit;
                                lamp_next[3 * int'(sf_q) + 1] = 1'b0;
                                lamp_next[3 * int'(sf_q) + 2] = 1'b0;
                            end
                            to_next = 1'b1;
                            em = 1'b1;
                            em_type = ecc_pkg::CT_SERVED_UP;
                        end
                    end
                end
            end
            ecc_pkg::PH_CLR:
            begin
                // clear the hall lamp in the direction of departure
                fbit = FL'(1) << lsf_reg;
                if (lsf_reg == FW'(FL - 1))
                    kind = ecc_pkg::DIR_DOWN;
                else if (lsf_reg == '0)
                    kind = ecc_pkg::DIR_UP;
                else
                    kind = dir_reg;
                if (clrp_reg && kind == ecc_pkg::DIR_UP)
                begin
                    lamp_next[3 * int'(lsf_reg) + 1] = 1'b0;
                    if ((up_reg & fbit) != '0)
                    begin
                        up_next = up_reg & ~fbit;
                        em = 1'b1;
                        em_type = ecc_pkg::CT_SERVED_UP;
                        em_floor = $signed({1'b0, lsf_reg});
                    end
                end
                else if (clrp_reg && kind == ecc_pkg::DIR_DOWN)
                begin
                    lamp_next[3 * int'(lsf_reg) + 2] = 1'b0;
                    if ((dn_reg & fbit) != '0)
                    begin
                        dn_next = dn_reg & ~fbit;
                        em = 1'b1;
                        em_type = ecc_pkg::CT_SERVED_DOWN;
                        em_floor = $signed({1'b0, lsf_reg});
                    end
                end
            end
            ecc_pkg::PH_WAIT2:
            begin
                if (to_reg)
                begin
                    em = 1'b1;
                    em_type = ecc_pkg::CT_SERVED_DOWN;
                end
            end
            ecc_pkg::PH_KA:
            begin
                if ((time_q - lrt_reg) >= {16'd0, kat_reg})
                begin
                    em = 1'b1;
                    em_type = ecc_pkg::CT_KEEPALIVE;
                end
            end
            ecc_pkg::PH_END:
            begin
                fb_next = cf;
                em = 1'b1;
                em_last = 1'b1;
                em_type = ecc_pkg::CT_STEP_END;
            end
            default: ;
        endcase

        lrt_next = (em && em_type < ecc_pkg::CT_STEP_END) ? time_q : lrt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ecc_pkg::MODE_NORMAL;
            dir_reg   <= ecc_pkg::DIR_NONE;
            pdir_reg  <= ecc_pkg::DIR_NONE;
            lsf_reg   <= '0;
            shown_reg <= '0;
            ins_reg   <= '0;
            up_reg    <= '0;
            dn_reg    <= '0;
            ipb_reg   <= '0;
            pn_reg    <= '0;
            lamp_reg  <= '0;
            stopb_reg <= 1'b0;
            estop_reg <= 1'b0;
            fb_reg    <= ecc_pkg::FLOOR_UNKNOWN;
            dst_reg   <= '0;
            lrt_reg   <= '0;
            dwt_reg   <= 16'd3000;
            kat_reg   <= 16'd1000;
            clrp_reg  <= 1'b0;
            to_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == ecc_pkg::CFG_DOOR_WAIT)
                dwt_reg <= cfg_data;
            if (cfg_we && cfg_index == ecc_pkg::CFG_KEEP_ALIVE)
                kat_reg <= cfg_data;
            if (accept)
                pn_reg <= '0;
            else if (go)
            begin
                mode_reg  <= mode_next;
                dir_reg   <= dir_next;
                pdir_reg  <= pdir_next;
                lsf_reg   <= lsf_next;
                shown_reg <= shown_next;
                ins_reg   <= ins_next;
                up_reg    <= up_next;
                dn_reg    <= dn_next;
                ipb_reg   <= ipb_next;
                pn_reg    <= pn_next;
                lamp_reg  <= lamp_next;
                stopb_reg <= stopb_next;
                estop_reg <= estop_next;
                fb_reg    <= fb_next;
                dst_reg   <= dst_next;
                lrt_reg   <= lrt_next;
                clrp_reg  <= clrp_next;
                to_reg    <= to_next;
            end
            if (go && em)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item latch and record register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sig_q  <= button_signals;
            stop_q <= stop_button;
            obs_q  <= obstruction;
            sok_q  <= !floor_sensor[2] && (int'(floor_sensor) < FL);
            sf_q   <= floor_sensor[FW-1:0];
            act_q  <= action;
            cfl_q  <= command_floor;
            time_q <= time_now;
        end
        if (go && em)
        begin
            out_ch.change_type     <= em_type;
            out_ch.change_floor    <= em_floor;
            out_ch.last_floor      <= lsf_next;
            out_ch.direction       <= dir_next;
            out_ch.inside_requests <= ins_next;
            out_ch.up_requests     <= up_next;
            out_ch.down_requests   <= dn_next;
            out_ch.stopped         <= estop_next;
            out_ch.lamps           <= lamp_next;
            out_ch.floor_indicator <= shown_next;
            out_ch.timestamp       <= time_q;
            out_ch.last_of_step    <= em_last;
        end
    end

    assign out_ch.valid = out_valid_reg;

endmodule

>>> rtl/elevator_car_controller_core.sv
// ---------------------------------------------------------------------------
// elevator_car_controller_core: elevator car controller
// Takes one poll item per step and emits its state-change records, ending
// with a step-end (or halted) record.
// ---------------------------------------------------------------------------
// channel   dir  handshake      payload
// in_ch     in   valid/ready    buttons, stop, obstruction, sensor, command, time
// out_ch    out  valid/ready    one state-change record per item
// cfg       in   cfg_we         cfg_index selects door wait / keep-alive time
//
// An item walks the sequencer through halt, buttons, stop, obstruction, command,
// floor, main, clear, wait2, keep-alive and end; a halted controller ends at halt.
// Each phase waits while the record register holds an untaken record.
// Reset: normal mode, lowest floor, no requests, door wait 3000, keep-alive 1000.
// ---------------------------------------------------------------------------
module elevator_car_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    ecc_in_if.sink      in_ch,
    ecc_out_if.source   out_ch
);

    ecc_pkg::cmd_t  cmd;
    ecc_pkg::stat_t stat;
    logic accept;

    assign accept = in_ch.valid && in_ch.ready;

    ecc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ecc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .accept         (accept),
        .button_signals (in_ch.button_signals),
        .stop_button    (in_ch.stop_button),
        .obstruction    (in_ch.obstruction),
        .floor_sensor   (in_ch.floor_sensor),
        .action         (in_ch.action),
        .command_floor  (in_ch.command_floor),
        .time_now       (in_ch.time_now),
        .cmd            (cmd),
        .stat           (stat),
        .out_ch         (out_ch)
    );

endmodule

>>> sim/elevator_car_controller_core_tb.sv
// ---------------------------------------------------------------------------
// elevator_car_controller_core_tb: self-checking bench for the car controller
// Drives poll items with random gaps, predicts every state-change record in a
// scoreboard and checks each record taken from the output channel in order.
// ---------------------------------------------------------------------------
typedef struct packed {
    logic [3:0]        change_type;
    logic signed [2:0] change_floor;
    logic [1:0]        last_floor;
    logic [1:0]        direction;
    logic [3:0]        inside_requests;
    logic [3:0]        up_requests;
    logic [3:0]        down_requests;
    logic              stopped;
    logic [13:0]       lamps;
    logic [1:0]        floor_indicator;
    logic [31:0]       timestamp;
    logic              last_of_step;
} car_rec_t;

class car_scoreboard;
    // controller state mirror
    logic [1:0]  mode;
    logic [1:0]  dir;
    logic [1:0]  prev_dir;
    logic [1:0]  lsf;
    logic [3:0]  ins_req;
    logic [3:0]  up_req;
    logic [3:0]  dn_req;
    logic [3:0]  pressed_prev;
    logic [13:0] lamp_q;
    logic        stop_prev;
    logic        estop;
    int          floor_prev;
    logic [1:0]  shown;
    logic [31:0] door_t0;
    logic [31:0] rec_t0;
    logic [15:0] door_wait;
    logic [15:0] keep_alive;
    // per-item scratch
    logic [31:0] now;
    int          sensor;
    int          n_step;

    car_rec_t    pending[$];
    int          mismatches;

    function new();
        mode = ecc_pkg::MODE_NORMAL;
        dir = ecc_pkg::DIR_NONE;
        prev_dir = ecc_pkg::DIR_NONE;
        lsf = '0;
        ins_req = '0;
        up_req = '0;
        dn_req = '0;
        pressed_prev = '0;
        lamp_q = '0;
        stop_prev = 1'b0;
        estop = 1'b0;
        floor_prev = -1;
        shown = '0;
        door_t0 = '0;
        rec_t0 = '0;
        door_wait = 16'd3000;
        keep_alive = 16'd1000;
        mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
        if (idx == ecc_pkg::CFG_DOOR_WAIT)
            door_wait = val;
        else
            keep_alive = val;
    endfunction

    function void put(logic [3:0] ct, int fl, logic last);
        car_rec_t r;
        if (n_step >= 20)
            return;
        r.change_type = ct;
        r.change_floor = fl[2:0];
        r.last_floor = lsf;
        r.direction = dir;
        r.inside_requests = ins_req;
        r.up_requests = up_req;
        r.down_requests = dn_req;
        r.stopped = estop;
        r.lamps = lamp_q;
        r.floor_indicator = shown;
        r.timestamp = now;
        r.last_of_step = last;
        pending = {pending, r};
        n_step++;
        if (ct < ecc_pkg::CT_STEP_END)
            rec_t0 = now;
    endfunction

    function int sense();
        if (sensor >= 0)
            lsf = sensor[1:0];
        return sensor;
    endfunction

    function void park();
        if (dir != ecc_pkg::DIR_NONE)
            prev_dir = dir;
        dir = ecc_pkg::DIR_NONE;
    endfunction

    function logic [1:0] pick_dir();
        logic [3:0] s;
        int hi;
        int lo;
        s = (ins_req == '0) ? (up_req | dn_req) : ins_req;
        hi = 0;
        lo = 0;
        for (int f = 0; f < ecc_pkg::FLOORS; f++)
        begin
            if (s[f] && f > int'(lsf))
                hi++;
            if (s[f] && f < int'(lsf))
                lo++;
        end
        return (hi >= lo) ? ecc_pkg::DIR_UP : ecc_pkg::DIR_DOWN;
    endfunction

    function void depart(logic [1:0] d);
        int unused;
        dir = d;
        unused = sense();
        if (lsf == 2'd0)
            dir = ecc_pkg::DIR_UP;
        else if (lsf == 2'd3)
            dir = ecc_pkg::DIR_DOWN;
        if (dir == ecc_pkg::DIR_NONE)
            dir = pick_dir();
        lamp_q[ecc_pkg::DOOR_BIT] = 1'b0;
    endfunction

    function logic stop_here(int f);
        logic [3:0] bm;
        logic [3:0] all_m;
        bm = 4'd1 << f;
        all_m = ins_req | up_req | dn_req;
        if ((ins_req & bm) != 0)
            return 1'b1;
        if (dir == ecc_pkg::DIR_UP && (up_req & bm) != 0)
            return 1'b1;
        if (dir == ecc_pkg::DIR_DOWN && (dn_req & bm) != 0)
            return 1'b1;
        return ((all_m & bm) != 0) &&
               ((all_m & ~bm) == 0 || all_m == up_req || all_m == dn_req);
    endfunction

    function logic inside_ahead(logic [1:0] d);
        logic [3:0] below;
        logic [3:0] above;
        below = (4'd1 << lsf) - 4'd1;
        above = ~(below | (4'd1 << lsf));
        if (d == ecc_pkg::DIR_DOWN)
            return (ins_req & below) != 0;
        if (d == ecc_pkg::DIR_UP)
            return (ins_req & above) != 0;
        return 1'b0;
    endfunction

    function void clear_hall_lamp();
        int f;
        logic [1:0] kind;
        f = lsf;
        if (f == ecc_pkg::FLOORS - 1)
            kind = ecc_pkg::DIR_DOWN;
        else if (f == 0)
            kind = ecc_pkg::DIR_UP;
        else if (dir != ecc_pkg::DIR_NONE)
            kind = dir;
        else
            return;
        if (kind == ecc_pkg::DIR_UP)
        begin
            lamp_q[3 * f + 1] = 1'b0;
            if (up_req[f])
            begin
                up_req[f] = 1'b0;
                put(ecc_pkg::CT_SERVED_UP, f, 1'b0);
            end
        end
        else
        begin
            lamp_q[3 * f + 2] = 1'b0;
            if (dn_req[f])
            begin
                dn_req[f] = 1'b0;
                put(ecc_pkg::CT_SERVED_DOWN, f, 1'b0);
            end
        end
    endfunction

    // predict all records of one accepted poll item
    function void note_item(logic [11:0] btn, logic stp, logic obs, logic [2:0] sens,
                            logic [2:0] act, logic [1:0] cfl, logic [31:0] tnow);
        logic [3:0] pn;
        logic [3:0] pl;
        logic up_ok;
        logic dn_ok;
        logic tmo;
        logic ex;
        logic [3:0] ct;
        int b;
        int c;
        now = tnow;
        n_step = 0;
        sensor = sens[2] ? -1 : int'(sens[1:0]);
        if (mode == ecc_pkg::MODE_HALTED)
        begin
            put(ecc_pkg::CT_HALTED, -1, 1'b1);
            return;
        end
        pl = pressed_prev;
        pn = '0;
        for (int f = 0; f < ecc_pkg::FLOORS; f++)
            for (int k = 0; k < 3; k++)
            begin
                b = 3 * f + k;
                ex = (k == 1) ? (f < ecc_pkg::FLOORS - 1) : (k == 2) ? (f > 0) : 1'b1;
                if (ex && btn[b])
                begin
                    if (!lamp_q[b])
                    begin
                        lamp_q[b] = 1'b1;
                        if (k == 0)
                            ins_req[f] = 1'b1;
                        if (k == 0)
                            ct = ecc_pkg::CT_IN_PRESSED;
                        else if (k == 1)
                            ct = ecc_pkg::CT_UP_PRESSED;
                        else
                            ct = ecc_pkg::CT_DOWN_PRESSED;
                        put(ct, f, 1'b0);
                    end
                    if (k == 0)
                        pn[f] = 1'b1;
                end
            end
        pressed_prev = pn;

        if (stp && !stop_prev)
        begin
            estop = !lamp_q[ecc_pkg::STOP_BIT];
            if (estop)
            begin
                lamp_q[ecc_pkg::STOP_BIT] = 1'b1;
                park();
                mode = ecc_pkg::MODE_STOPPED;
            end
            else
            begin
                lamp_q[ecc_pkg::STOP_BIT] = 1'b0;
                depart(prev_dir);
                mode = ecc_pkg::MODE_NORMAL;
            end
            put(ecc_pkg::CT_OTHER, sense(), 1'b0);
        end
        stop_prev = stp;

        if (obs)
        begin
            park();
            mode = ecc_pkg::MODE_HALTED;
            put(ecc_pkg::CT_HALTED, -1, 1'b1);
            return;
        end

        up_ok = cfl < ecc_pkg::FLOORS - 1;
        dn_ok = cfl > 0;
        case (act)
            ecc_pkg::ACT_CALL_UP:
                if (up_ok)
                begin
                    up_req[cfl] = 1'b1;
                    lamp_q[3 * cfl + 1] = 1'b1;
                end
            ecc_pkg::ACT_CALL_DN:
                if (dn_ok)
                begin
                    dn_req[cfl] = 1'b1;
                    lamp_q[3 * cfl + 2] = 1'b1;
                end
            ecc_pkg::ACT_UP_ON:  if (up_ok) lamp_q[3 * cfl + 1] = 1'b1;
            ecc_pkg::ACT_UP_OFF: if (up_ok) lamp_q[3 * cfl + 1] = 1'b0;
            ecc_pkg::ACT_DN_ON:  if (dn_ok) lamp_q[3 * cfl + 2] = 1'b1;
            ecc_pkg::ACT_DN_OFF: if (dn_ok) lamp_q[3 * cfl + 2] = 1'b0;
            default: ;
        endcase

        c = sense();
        if (c == ecc_pkg::FLOORS - 1 && dir == ecc_pkg::DIR_UP)
            park();
        if (c == 0 && dir == ecc_pkg::DIR_DOWN)
            park();
        if (c >= 0)
            shown = c[1:0];
        if (c != floor_prev)
            put(ecc_pkg::CT_OTHER, c, 1'b0);

        if (mode == ecc_pkg::MODE_NORMAL)
        begin
            if (c >= 0 && stop_here(c))
            begin
                lamp_q[3 * c] = 1'b0;
                ins_req[c] = 1'b0;
                lamp_q[ecc_pkg::DOOR_BIT] = 1'b1;
                mode = ecc_pkg::MODE_WAIT;
                door_t0 = now;
                park();
                put(ecc_pkg::CT_SERVED, c, 1'b0);
            end
            else if (dir == ecc_pkg::DIR_NONE)
            begin
                if ((ins_req | up_req | dn_req) != 0)
                begin
                    if (inside_ahead(prev_dir))
                        depart(prev_dir);
                    else
                        depart(ecc_pkg::DIR_NONE);
                    put(ecc_pkg::CT_OTHER, c, 1'b0);
                end
                clear_hall_lamp();
            end
        end
        else if (mode == ecc_pkg::MODE_WAIT)
        begin
            tmo = (now - door_t0) > {16'd0, door_wait};
            if ((pn & ~pl) != 0 || tmo)
            begin
                lamp_q[ecc_pkg::DOOR_BIT] = 1'b0;
                mode = ecc_pkg::MODE_NORMAL;
                if (tmo)
                begin
                    if (c >= 0)
                    begin
                        dn_req[c] = 1'b0;
                        up_req[c] = 1'b0;
                        lamp_q[3 * c + 1] = 1'b0;
                        lamp_q[3 * c + 2] = 1'b0;
                    end
                    put(ecc_pkg::CT_SERVED_UP, c, 1'b0);
                    put(ecc_pkg::CT_SERVED_DOWN, c, 1'b0);
                end
            end
        end

        if ((now - rec_t0) >= {16'd0, keep_alive})
            put(ecc_pkg::CT_KEEPALIVE, c, 1'b0);

        floor_prev = c;
        put(ecc_pkg::CT_STEP_END, c, 1'b1);
    endfunction

    function void check_rec(car_rec_t got);
        car_rec_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected record: %p", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("record mismatch\n  expected %p\n  actual   %p", want, got);
        end
    endfunction
endclass

module elevator_car_controller_core_tb;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    ecc_in_if  in_ch();
    ecc_out_if out_ch();

    elevator_car_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    car_scoreboard sb;
    int            src_idle;
    int            dst_idle;
    int            cycles;
    logic [31:0]   clock_ms;
    int            car_pos;   // half-floor steps, even = at a floor

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // record sink
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_rec({out_ch.change_type, out_ch.change_floor, out_ch.last_floor,
                          out_ch.direction, out_ch.inside_requests, out_ch.up_requests,
                          out_ch.down_requests, out_ch.stopped, out_ch.lamps,
                          out_ch.floor_indicator, out_ch.timestamp, out_ch.last_of_step});
        out_ch.ready <= ($urandom_range(99) >= dst_idle);
    end

    task automatic send_poll(logic [11:0] btn, logic stp, logic obs, logic [2:0] sens,
                             logic [2:0] act, logic [1:0] cfl, logic [31:0] tnow);
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.button_signals <= btn;
        in_ch.stop_button <= stp;
        in_ch.obstruction <= obs;
        in_ch.floor_sensor <= sens;
        in_ch.action <= act;
        in_ch.command_floor <= cfl;
        in_ch.time_now <= tnow;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_item(btn, stp, obs, sens, act, cfl, tnow);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // random poll: sensor follows the predicted car motion, with occasional random codes
    task automatic random_poll(logic obs);
        logic [11:0] btn;
        logic [2:0]  sens;
        logic [2:0]  act;
        if (sb.dir == ecc_pkg::DIR_UP && car_pos < 6)
            car_pos++;
        else if (sb.dir == ecc_pkg::DIR_DOWN && car_pos > 0)
            car_pos--;
        sens = car_pos[0] ? 3'b111 : 3'(car_pos / 2);
        if ($urandom_range(99) < 8)
            sens = 3'($urandom_range(7));
        btn = '0;
        if ($urandom_range(99) < 15)
            btn = 12'($urandom);
        else
            for (int b = 0; b < 12; b++)
                if ($urandom_range(99) < 6)
                    btn[b] = 1'b1;
        act = ($urandom_range(99) < 35) ? 3'($urandom_range(7)) : 3'd0;
        case ($urandom_range(9))
            0: clock_ms = clock_ms + $urandom_range(6000);
            1: clock_ms = clock_ms + $urandom;
            default: clock_ms = clock_ms + $urandom_range(500);
        endcase
        send_poll(btn, ($urandom_range(99) < 6), obs, sens, act,
                  2'($urandom_range(3)), clock_ms);
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        cfg_we = 1'b0;
        cfg_index = ecc_pkg::CFG_DOOR_WAIT;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.button_signals = '0;
        in_ch.stop_button = 1'b0;
        in_ch.obstruction = 1'b0;
        in_ch.floor_sensor = '0;
        in_ch.action = '0;
        in_ch.command_floor = '0;
        in_ch.time_now = '0;
        out_ch.ready = 1'b0;
        src_idle = 36;
        dst_idle = 56;
        car_pos = 0;
        clock_ms = 32'hFFFF_F000;   // crosses the 32-bit wrap early
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, extremes, every command, sensor codes
        send_poll(12'h000, 1'b0, 1'b0, 3'd0, 3'd0, 2'd0, 32'd0);
        send_poll(12'hFFF, 1'b0, 1'b0, 3'd0, 3'd0, 2'd0, 32'd5);
        send_poll(12'h000, 1'b1, 1'b0, 3'b111, 3'd0, 2'd3, 32'hFFFF_FFFF);
        send_poll(12'h000, 1'b0, 1'b0, 3'b100, 3'd0, 2'd3, 32'hFFFF_FFFF);
        send_poll(12'h000, 1'b1, 1'b0, 3'd1, 3'd0, 2'd0, 32'h0000_0100);
        for (int a = 1; a < 8; a++)
            for (int f = 0; f < ecc_pkg::FLOORS; f += 3)
                send_poll(12'h000, 1'b0, 1'b0, 3'($urandom_range(3)), 3'(a), 2'(f),
                          clock_ms + 32'(a * 700));
        send_poll(12'h249, 1'b0, 1'b0, 3'd2, ecc_pkg::ACT_CALL_UP, 2'd1, 32'h0001_0000);
        send_poll(12'h492, 1'b0, 1'b0, 3'd3, ecc_pkg::ACT_CALL_DN, 2'd2, 32'h0002_0000);
        send_poll(12'h924, 1'b0, 1'b0, 3'b101, 3'd7, 2'd2, 32'h7FFF_FFFF);
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(ecc_pkg::CFG_DOOR_WAIT, 16'd0);
                    write_reg(ecc_pkg::CFG_KEEP_ALIVE, 16'hFFFF);
                end
                1:
                begin
                    write_reg(ecc_pkg::CFG_DOOR_WAIT, 16'hFFFF);
                    write_reg(ecc_pkg::CFG_KEEP_ALIVE, 16'd0);
                end
                default:
                begin
                    write_reg(ecc_pkg::CFG_DOOR_WAIT, 16'($urandom_range(3000)));
                    write_reg(ecc_pkg::CFG_KEEP_ALIVE, 16'($urandom_range(2000)));
                end
            endcase
            src_idle = (ph == 0) ? 36 : (ph == 1) ? 56 : 0;
            dst_idle = (ph == 0) ? 56 : (ph == 1) ? 36 : 0;
            clock_ms = (ph == 1) ? 32'hFFFF_0000 : $urandom;
            for (int i = 0; i < 40; i++)
                random_poll(1'b0);
            drain();
        end

        // obstruction halts the block for good
        src_idle = 0;
        dst_idle = 0;
        random_poll(1'b1);
        for (int i = 0; i < 5; i++)
            random_poll(1'($urandom_range(1)));
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

>>> elevator_car_controller_core.f
rtl/ecc_pkg.sv
rtl/ecc_in_if.sv
rtl/ecc_ctrl.sv
rtl/ecc_datapath.sv
rtl/elevator_car_controller_core.sv
sim/elevator_car_controller_core_tb.sv
